// File: src/url_pd_pkg.sv
// ----------------------------------------------------------------------------
// url_pd_pkg: shared types and constants of the URL percent decoder
// Payload structs for both channels, character codes and hex digit helpers.
// ----------------------------------------------------------------------------
package url_pd_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       message_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       message_end;
  } out_item_t;

  localparam logic [7:0] PCT_CHAR = 8'h25;
  localparam logic [7:0] U_LOWER  = 8'h75;
  localparam logic [7:0] U_UPPER  = 8'h55;

  // True for 0-9, a-f and A-F; bytes at or above 0x80 never qualify.
  function automatic logic is_hex(input logic [7:0] c);
    logic dig;
    logic low;
    logic upp;
    dig = (c >= 8'h30) && (c <= 8'h39);
    low = (c >= 8'h61) && (c <= 8'h66);
    upp = (c >= 8'h41) && (c <= 8'h46);
    return dig || low || upp;
  endfunction

  // Nibble value of a hex digit. Letters share their low bits in both cases.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] v;
    if (c[6]) begin
      v = c[3:0] + 4'd9;
    end else begin
      v = c[3:0];
    end
    return v;
  endfunction

endpackage

// File: src/url_pd_stream_if.sv
// ----------------------------------------------------------------------------
// url_pd_stream_if: valid/ready channel of the URL percent decoder
// Carries one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface url_pd_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// File: src/url_percent_decoder_core.sv
// Timing: an accepted transaction's plan is registered, then the result sequencer loads each
//   result into the output register. An input causing n results (1 to 6) holds off the input
//   until the single result sequencer has emitted all n; an input with no result does not.
// A new byte is therefore not accepted until the results of the previous one have been emitted.
// Reset: synchronous, active low; clears escape state and sequencer, held bytes keep contents.
// ----------------------------------------------------------------------------
// url_percent_decoder_core: streaming URL percent decoder
// Decodes %XX escapes, swallows %uXXXX escapes and replays malformed or unfinished ones.
// ----------------------------------------------------------------------------
module url_percent_decoder_core (
  input  logic             clk,
  input  logic             rst_n,
  url_pd_stream_if.sink    in_stream,
  url_pd_stream_if.source  out_stream
);

  // Escape phases: idle, '%' seen, '%' plus one hex digit, "%u" plus
  // zero to three hex digits. The unused code behaves as idle.
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_PCT  = 3'd1;
  localparam logic [2:0] PH_HEX1 = 3'd2;
  localparam logic [2:0] PH_U0   = 3'd3;
  localparam logic [2:0] PH_U1   = 3'd4;
  localparam logic [2:0] PH_U2   = 3'd5;
  localparam logic [2:0] PH_U3   = 3'd6;

  // Escape state.
  logic [2:0] phase_r, phase_nxt;
  logic [2:0] held_cnt_r, held_cnt_nxt;
  logic [7:0] held_r [4];

  // Per-transaction emission plan. The results of one input form up to
  // three segments: the replay of an aborted escape ('%' and the old held
  // bytes), one middle byte (passed through or decoded), and the end of
  // message flush ('%' and the new held bytes). Segment bounds are kept as
  // result indexes: old segment below seg_a_r, middle below seg_b_r, the
  // rest is the flush, or the empty end marker when no flush is pending.
  logic       busy_r;
  logic [2:0] seg_a_r;
  logic [2:0] seg_b_r;
  logic [2:0] total_r;
  logic [2:0] idx_r;
  logic       flush_new_r;
  logic       last_r;
  logic [7:0] mid_byte_r;

  logic                 out_valid_r;
  url_pd_pkg::out_item_t out_item_r;

  // Input side decode.
  logic       in_fire;
  logic [7:0] c;
  logic       c_hex;
  logic       c_pct;
  logic       c_u;
  logic       hold_en;
  logic       malformed;
  logic       mid_v;
  logic [7:0] mid_b;
  logic [2:0] phase_after;
  logic [2:0] cnt_after;
  logic       flush_new;
  logic [2:0] seg_a;
  logic [2:0] seg_b;
  logic [2:0] total;

  assign in_stream.ready = !busy_r;
  assign in_fire = in_stream.valid && !busy_r;
  assign c       = in_stream.data.in_byte;
  assign c_hex   = url_pd_pkg::is_hex(c);
  assign c_pct   = (c == url_pd_pkg::PCT_CHAR);
  assign c_u     = (c == url_pd_pkg::U_LOWER) || (c == url_pd_pkg::U_UPPER);

  always_comb begin
    hold_en     = 1'b0;
    malformed   = 1'b0;
    mid_v       = 1'b0;
    mid_b       = c;
    phase_after = phase_r;
    cnt_after   = held_cnt_r;
    case (phase_r)
      PH_PCT: begin
        if (c_u) begin
          hold_en     = 1'b1;
          phase_after = PH_U0;
        end else if (c_hex) begin
          hold_en     = 1'b1;
          phase_after = PH_HEX1;
        end else begin
          malformed = 1'b1;
        end
      end
      PH_HEX1: begin
        if (c_hex) begin
          mid_v       = 1'b1;
          mid_b       = {url_pd_pkg::hex_nibble(held_r[0]), url_pd_pkg::hex_nibble(c)};
          phase_after = PH_IDLE;
          cnt_after   = 3'd0;
        end else begin
          malformed = 1'b1;
        end
      end
      PH_U0, PH_U1, PH_U2: begin
        if (c_hex) begin
          hold_en     = 1'b1;
          phase_after = phase_r + 3'd1;
        end else begin
          malformed = 1'b1;
        end
      end
      PH_U3: begin
        // A complete %uXXXX escape is consumed without output.
        if (c_hex) begin
          phase_after = PH_IDLE;
          cnt_after   = 3'd0;
        end else begin
          malformed = 1'b1;
        end
      end
      default: begin
        cnt_after = 3'd0;
        if (c_pct) begin
          phase_after = PH_PCT;
        end else begin
          phase_after = PH_IDLE;
          mid_v       = 1'b1;
        end
      end
    endcase

    // An aborted escape is replayed, then the current byte is handled
    // from idle, so a '%' here opens a fresh escape.
    if (malformed) begin
      cnt_after = 3'd0;
      if (c_pct) begin
        phase_after = PH_PCT;
      end else begin
        phase_after = PH_IDLE;
        mid_v       = 1'b1;
      end
    end

    if (hold_en) begin
      cnt_after = held_cnt_r + 3'd1;
    end

    flush_new = in_stream.data.message_last && (phase_after != PH_IDLE) &&
                (phase_after <= PH_U3);
    seg_a = malformed ? (held_cnt_r + 3'd1) : 3'd0;
    seg_b = seg_a + {2'b00, mid_v};
    total = seg_b + (flush_new ? (cnt_after + 3'd1) : 3'd0);
    // A last byte with nothing to show still marks the message end.
    if (in_stream.data.message_last && (total == 3'd0)) begin
      total = 3'd1;
    end

    phase_nxt    = flush_new ? PH_IDLE : phase_after;
    held_cnt_nxt = flush_new ? 3'd0 : cnt_after;
  end

  // Result sequencer: one result per cycle while the output is not stalled, selected by result index.
  logic                  emit_go;
  logic [2:0]            rd_off;
  logic [1:0]            rd_idx;
  logic                  emit_last;
  url_pd_pkg::out_item_t emit_item;

  assign emit_go   = busy_r && (!out_valid_r || out_stream.ready);
  assign emit_last = (idx_r == 3'(total_r - 3'd1));
  assign rd_off    = (idx_r < seg_a_r) ? 3'(idx_r - 3'd1) : 3'(idx_r - seg_b_r - 3'd1);
  assign rd_idx    = rd_off[1:0];

  always_comb begin
    emit_item.out_byte    = 8'h00;
    emit_item.byte_valid  = 1'b1;
    emit_item.run_last    = emit_last;
    emit_item.message_end = emit_last && last_r;
    if (idx_r < seg_a_r) begin
      emit_item.out_byte = (idx_r == 3'd0) ? url_pd_pkg::PCT_CHAR : held_r[rd_idx];
    end else if (idx_r < seg_b_r) begin
      emit_item.out_byte = mid_byte_r;
    end else if (flush_new_r) begin
      emit_item.out_byte = (idx_r == seg_b_r) ? url_pd_pkg::PCT_CHAR : held_r[rd_idx];
    end else begin
      emit_item.byte_valid = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      held_cnt_r  <= 3'd0;
      busy_r      <= 1'b0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r    <= phase_nxt;
        held_cnt_r <= held_cnt_nxt;
        busy_r     <= (total != 3'd0);
        idx_r      <= 3'd0;
      end else if (emit_go) begin
        idx_r <= idx_r + 3'd1;
        if (emit_last) begin
          busy_r <= 1'b0;
        end
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_stream.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers and held byte store.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      seg_a_r     <= seg_a;
      seg_b_r     <= seg_b;
      total_r     <= total;
      flush_new_r <= flush_new;
      last_r      <= in_stream.data.message_last;
      mid_byte_r  <= mid_b;
      if (hold_en) begin
        held_r[held_cnt_r[1:0]] <= c;
      end
    end
    if (emit_go) begin
      out_item_r <= emit_item;
    end
  end

  assign out_stream.valid = out_valid_r;
  assign out_stream.data  = out_item_r;

`ifndef SYNTHESIS
  logic out_fire;
  assign out_fire = out_stream.valid && out_stream.ready;

  a_empty_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_stream.data.byte_valid |->
      out_stream.data.run_last && out_stream.data.message_end)
    else $error("empty result without end marks");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_stream.data.message_last |=> busy_r)
    else $error("message end produced no result");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r < total_r))
    else $error("result sequencer overran its plan");

  a_held_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (held_cnt_r <= 3'd4) && ((phase_r != PH_IDLE) || (held_cnt_r == 3'd0)))
    else $error("held byte count inconsistent with escape phase");
`endif

endmodule
